>>> hdl/swrl_pkg.sv
package swrl_pkg;

  // item operations
  localparam logic OP_CHECK  = 1'b0;
  localparam logic OP_RECORD = 1'b1;

  // register indexes
  localparam logic [1:0] REG_MINUTE_LIMIT = 2'd0;
  localparam logic [1:0] REG_HOUR_LIMIT   = 2'd1;
  localparam logic [1:0] REG_ENABLE       = 2'd2;

  // field widths
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned PROV_W  = 3;
  localparam int unsigned EN_W    = 8;

  // window ages in seconds
  localparam logic [TIME_W:0] PRUNE_AGE  = 33'd3660;
  localparam logic [TIME_W:0] MINUTE_AGE = 33'd60;

  // register resets
  localparam logic [CNT_W-1:0] MINUTE_LIMIT_RST = 11'd60;
  localparam logic [CNT_W-1:0] HOUR_LIMIT_RST   = 11'd1000;
  localparam logic [EN_W-1:0]  ENABLE_RST       = 8'd15;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_DONE,
    ST_OUT
  } state_t;

  // saturating increment
  function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
    sat_inc = (v == {TOTAL_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

>>> hdl/sliding_window_rate_limiter_unit.sv
// channel | dir | handshake          | payload
// in      | in  | in_tvalid/tready   | tdata: operation, provider, now_seconds
// out     | out | out_tvalid/tready  | tdata: allowed, minute_count, hour_count,
//         |     |                    |        refused_total, recorded_total, provider_total
// cfg     | in  | cfg_valid/ready    | cfg_index, cfg_data
// A record item, or a check on a provider that is not limited, goes from SCAN
// straight to DONE and OUT. A limited check walks the provider's log through one
// memory port, one entry a cycle (fill <= LOG_DEPTH), then passes WAIT and DONE to OUT.
// One item at a time; in_tready is high only while idle, from the cycle after
// the result is taken.
// The log memory needs no clearing; fill counts and totals are cleared by reset.
// A stalled result holds in the output register until taken.
module sliding_window_rate_limiter_unit #(
  parameter int unsigned PROVIDERS = 8,
  parameter int unsigned LOG_DEPTH = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [0] operation, [3:1] provider, [35:4] now_seconds, [39:36] zero
  input  logic [39:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [0] allowed, [11:1] minute_count, [22:12] hour_count, [54:23] refused_total,
  // [86:55] recorded_total, [118:87] provider_total, [119] zero
  output logic [119:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [10:0]  cfg_data
);
  import swrl_pkg::*;

  localparam int unsigned PI_W  = (PROVIDERS > 1) ? $clog2(PROVIDERS) : 1;
  localparam int unsigned SL_W  = $clog2(LOG_DEPTH);
  localparam int unsigned FL_W  = SL_W + 1;
  localparam int unsigned MEM_D = PROVIDERS * LOG_DEPTH;
  localparam int unsigned MA_W  = $clog2(MEM_D);

  // configuration registers
  logic [CNT_W-1:0] minute_limit_r;
  logic [CNT_W-1:0] hour_limit_r;
  logic [EN_W-1:0]  enable_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      minute_limit_r <= MINUTE_LIMIT_RST;
      hour_limit_r   <= HOUR_LIMIT_RST;
      enable_r       <= ENABLE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MINUTE_LIMIT: minute_limit_r <= cfg_data;
        REG_HOUR_LIMIT:   hour_limit_r   <= cfg_data;
        REG_ENABLE:       enable_r       <= cfg_data[EN_W-1:0];
        default: ;
      endcase
    end
  end

  // per-provider control state
  logic [SL_W-1:0]    oldest_r [PROVIDERS];
  logic [FL_W-1:0]    fill_r   [PROVIDERS];
  logic [TOTAL_W-1:0] ptot_r   [PROVIDERS];
  logic [TOTAL_W-1:0] refused_r, recorded_r;

  // item latch
  logic              op_r;
  logic [PROV_W-1:0] prov_r;
  logic [TIME_W-1:0] now_r;
  logic              pvalid;
  logic [PI_W-1:0]   pidx;
  logic              en_bit;
  logic              lim_chk;     // check on a valid, enabled provider

  assign pvalid  = ({{32-PROV_W{1'b0}}, prov_r} < PROVIDERS);
  assign pidx    = PI_W'(prov_r);
  assign en_bit  = (PROV_W'(prov_r) < EN_W) ? enable_r[prov_r] : 1'b0;
  assign lim_chk = (op_r == OP_CHECK) && pvalid && en_bit;

  // scan counters
  state_t state_r, state_nxt;
  logic [FL_W-1:0] left_r;      // entries still to issue
  logic [SL_W-1:0] rd_r, wr_r;
  logic            rvld_r;      // rdata_r holds a valid log word
  logic [FL_W-1:0] hcnt_r, mcnt_r;

  // log memory
  logic [TIME_W-1:0] mem [MEM_D];
  logic [TIME_W-1:0] rdata_r;
  logic              we;
  logic [MA_W-1:0]   waddr, raddr;
  logic [TIME_W-1:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  function automatic logic [SL_W-1:0] nxt(input logic [SL_W-1:0] s);
    nxt = ({{32-SL_W{1'b0}}, s} + 1 >= LOG_DEPTH) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [MA_W-1:0] addr(input logic [PI_W-1:0] p,
                                           input logic [SL_W-1:0] s);
    addr = MA_W'(p * LOG_DEPTH + {{32-SL_W{1'b0}}, s});
  endfunction

  // age of the word coming out of memory
  logic [TIME_W:0] age;
  logic            age_neg, keep, young;
  assign age     = {1'b0, now_r} - {1'b0, rdata_r};
  assign age_neg = age[TIME_W];
  assign keep    = age_neg || (age < PRUNE_AGE);
  assign young   = age_neg || (age < MINUTE_AGE);

  // record slot
  logic [SL_W-1:0] rec_slot;
  logic [SL_W:0]   sum;
  assign sum = {1'b0, oldest_r[pidx]} + fill_r[pidx][SL_W:0];
  assign rec_slot = (sum >= LOG_DEPTH) ? SL_W'(sum - LOG_DEPTH) : sum[SL_W-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = addr(pidx, rec_slot);
    wdata = now_r;
    raddr = addr(pidx, rd_r);
    if (state_r == ST_IDLE) begin
    end else if (op_r == OP_RECORD && state_r == ST_SCAN) begin
      we = pvalid;
      waddr = (fill_r[pidx] >= FL_W'(LOG_DEPTH)) ? addr(pidx, oldest_r[pidx])
                                                 : addr(pidx, rec_slot);
    end else if (rvld_r && keep) begin
      we    = 1'b1;
      waddr = addr(pidx, wr_r);
      wdata = rdata_r;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (op_r == OP_RECORD || !pvalid || !en_bit) state_nxt = ST_DONE;
        else if (left_r == '0) state_nxt = ST_WAIT;
      end
      ST_WAIT: state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_OUT;
      ST_OUT:  if (out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);

  logic              allowed_r;
  logic [CNT_W-1:0]  mout_r, hout_r;
  logic [TOTAL_W-1:0] ptout_r;
  logic              refuse;
  logic [CNT_W-1:0]  msat, hsat;
  assign msat = (mcnt_r > FL_W'(2047)) ? '1 : CNT_W'(mcnt_r);
  assign hsat = (hcnt_r > FL_W'(2047)) ? '1 : CNT_W'(hcnt_r);
  assign refuse = ({{32-FL_W{1'b0}}, mcnt_r} >= {21'd0, minute_limit_r}) ||
                  ({{32-FL_W{1'b0}}, hcnt_r} >= {21'd0, hour_limit_r});

  assign out_tdata = {1'b0, ptout_r, recorded_r, refused_r, hout_r, mout_r, allowed_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      refused_r  <= '0;
      recorded_r <= '0;
      rvld_r     <= 1'b0;
      op_r       <= OP_CHECK;
      prov_r     <= '0;
      now_r      <= '0;
      hcnt_r     <= '0;
      mcnt_r     <= '0;
      for (int i = 0; i < PROVIDERS; i++) begin
        oldest_r[i] <= '0;
        fill_r[i]   <= '0;
        ptot_r[i]   <= '0;
      end
    end else begin
      state_r <= state_nxt;
      rvld_r  <= (state_r == ST_SCAN) && lim_chk && (left_r != '0);
      unique case (state_r)
        ST_IDLE: if (in_tvalid) begin
          op_r   <= in_tdata[0];
          prov_r <= in_tdata[3:1];
          now_r  <= in_tdata[35:4];
        end
        ST_SCAN: begin
          if (op_r == OP_RECORD) begin
            recorded_r <= sat_inc(recorded_r);
            if (pvalid) begin
              if (fill_r[pidx] >= FL_W'(LOG_DEPTH)) oldest_r[pidx] <= nxt(oldest_r[pidx]);
              else fill_r[pidx] <= fill_r[pidx] + 1'b1;
              ptot_r[pidx] <= sat_inc(ptot_r[pidx]);
            end
          end else if (lim_chk && left_r != '0) begin
            rd_r   <= nxt(rd_r);
            left_r <= left_r - 1'b1;
          end
        end
        default: ;
      endcase
      // item accepted: set pointers
      if (state_r == ST_IDLE && in_tvalid) begin
        hcnt_r <= '0;
        mcnt_r <= '0;
        rd_r   <= oldest_r[PI_W'(in_tdata[3:1])];
        wr_r   <= oldest_r[PI_W'(in_tdata[3:1])];
        left_r <= fill_r[PI_W'(in_tdata[3:1])];
      end
      // result word from memory
      if (rvld_r && keep) begin
        wr_r   <= nxt(wr_r);
        hcnt_r <= hcnt_r + 1'b1;
        if (young) mcnt_r <= mcnt_r + 1'b1;
      end
      // finish
      if (state_r == ST_DONE) begin
        allowed_r <= !(lim_chk && refuse);
        mout_r    <= lim_chk ? msat : '0;
        hout_r    <= lim_chk ? hsat : '0;
        ptout_r   <= pvalid ? ptot_r[pidx] : '0;
        if (lim_chk) begin
          fill_r[pidx] <= hcnt_r;
          if (refuse) refused_r <= sat_inc(refused_r);
        end
      end
    end
  end

  // assertions
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r[pidx] <= FL_W'(LOG_DEPTH)) else $error("fill over depth");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input and output overlap");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    mcnt_r <= hcnt_r) else $error("minute count above hour count");
endmodule

>>> test/swrl_checker.sv
`timescale 1ns / 100ps

// Watches the input, result and register channels of the rate limiter,
// keeps its own copy of the per-provider logs and counters, and compares
// every result item with the oldest outstanding prediction.
module swrl_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [39:0]  in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [119:0] out_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [10:0]  cfg_data,
  output int           fail_count,
  output int           pending,
  output int           checks_seen,
  output int           refusals_seen
);
  import swrl_pkg::*;

  localparam int NPROV = 8;
  localparam int DEPTH = 1024;
  localparam longint WINDOW_HOUR = 3660;
  localparam longint WINDOW_MIN  = 60;

  typedef struct {
    logic               allowed;
    logic [CNT_W-1:0]   minute_cnt;
    logic [CNT_W-1:0]   hour_cnt;
    logic [TOTAL_W-1:0] refused;
    logic [TOTAL_W-1:0] recorded;
    logic [TOTAL_W-1:0] prov_total;
  } verdict_t;

  // model state
  logic [TIME_W-1:0]  stamps [NPROV][$];
  logic [TOTAL_W-1:0] refused_cnt;
  logic [TOTAL_W-1:0] recorded_cnt;
  logic [TOTAL_W-1:0] prov_cnt [NPROV];
  logic [CNT_W-1:0]   min_limit;
  logic [CNT_W-1:0]   hr_limit;
  logic [EN_W-1:0]    enable_mask;

  verdict_t verdicts [$];

  function automatic logic [TOTAL_W-1:0] bump(input logic [TOTAL_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] clip_count(input int c);
    return (c > 2047) ? 11'd2047 : c[CNT_W-1:0];
  endfunction

  // admission decision and log update for one accepted item
  function automatic verdict_t admit_request(input logic op, input logic [2:0] prov,
                                             input logic [TIME_W-1:0] now);
    verdict_t v;
    logic [TIME_W-1:0] kept [$];
    longint age;
    int mcnt;
    int hcnt;
    mcnt = 0;
    hcnt = 0;
    v.allowed = 1'b1;
    if (op == OP_RECORD) begin
      recorded_cnt = bump(recorded_cnt);
      if (stamps[prov].size() >= DEPTH) void'(stamps[prov].pop_front());
      stamps[prov] = {stamps[prov], now};
      prov_cnt[prov] = bump(prov_cnt[prov]);
    end else if (enable_mask[prov]) begin
      for (int i = 0; i < stamps[prov].size(); i++) begin
        age = $signed({32'd0, now}) - $signed({32'd0, stamps[prov][i]});
        if (age < WINDOW_HOUR) begin
          kept = {kept, stamps[prov][i]};
          hcnt++;
          if (age < WINDOW_MIN) mcnt++;
        end
      end
      stamps[prov] = kept;
      if (mcnt >= min_limit || hcnt >= hr_limit) begin
        v.allowed = 1'b0;
        refused_cnt = bump(refused_cnt);
      end
    end
    v.minute_cnt = clip_count(mcnt);
    v.hour_cnt   = clip_count(hcnt);
    v.refused    = refused_cnt;
    v.recorded   = recorded_cnt;
    v.prov_total = prov_cnt[prov];
    return v;
  endfunction

  function automatic void report(input string fname, input logic [31:0] want,
                                 input logic [31:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, fname, want, got);
  endfunction

  always @(posedge clk) begin
    verdict_t w;
    if (!rst_n) begin
      for (int p = 0; p < NPROV; p++) begin
        stamps[p].delete();
        prov_cnt[p] = '0;
      end
      refused_cnt  = '0;
      recorded_cnt = '0;
      min_limit    = MINUTE_LIMIT_RST;
      hr_limit     = HOUR_LIMIT_RST;
      enable_mask  = ENABLE_RST;
      verdicts.delete();
      fail_count    = 0;
      checks_seen   = 0;
      refusals_seen = 0;
    end else begin
      // result side first: it always belongs to an earlier item
      if (out_tvalid && out_tready) begin
        if (verdicts.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("%0t: result item with nothing expected", $realtime);
        end else begin
          w = verdicts.pop_front();
          if (out_tdata[0] !== w.allowed) report("allowed", w.allowed, out_tdata[0]);
          if (out_tdata[11:1] !== w.minute_cnt)
            report("minute_count", w.minute_cnt, out_tdata[11:1]);
          if (out_tdata[22:12] !== w.hour_cnt) report("hour_count", w.hour_cnt, out_tdata[22:12]);
          if (out_tdata[54:23] !== w.refused) report("refused_total", w.refused, out_tdata[54:23]);
          if (out_tdata[86:55] !== w.recorded)
            report("recorded_total", w.recorded, out_tdata[86:55]);
          if (out_tdata[118:87] !== w.prov_total)
            report("provider_total", w.prov_total, out_tdata[118:87]);
        end
      end
      if (in_tvalid && in_tready) begin
        w = admit_request(in_tdata[0], in_tdata[3:1], in_tdata[35:4]);
        verdicts = {verdicts, w};
        if (in_tdata[0] == OP_CHECK) begin
          checks_seen++;
          if (!w.allowed) refusals_seen++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MINUTE_LIMIT: min_limit = cfg_data;
          REG_HOUR_LIMIT:   hr_limit = cfg_data;
          REG_ENABLE:       enable_mask = cfg_data[EN_W-1:0];
          default: ;
        endcase
      end
    end
    pending = verdicts.size();
  end

endmodule

>>> test/tb_sliding_window_rate_limiter_unit.sv
`timescale 1ns / 100ps

module tb_sliding_window_rate_limiter_unit;
  import swrl_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [39:0]  in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [119:0] out_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [10:0]  cfg_data;

  int fail_count;
  int pending;
  int checks_seen;
  int refusals_seen;
  int items_sent;

  // 0: no gaps / no stalls, 1: random gaps and stalls
  bit tx_gaps;
  bit rx_stalls;
  int stall_left;
  int idle_cycles;

  logic [TIME_W-1:0] now_s;

  sliding_window_rate_limiter_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  swrl_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending),
    .checks_seen(checks_seen), .refusals_seen(refusals_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 15);
  endfunction

  // result-side backpressure
  always @(negedge clk) begin
    if (!rx_stalls) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      stall_left <= gap_len();
      out_tready <= 1'b1;
    end
  end

  // no-progress watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic op, input logic [2:0] prov, input logic [TIME_W-1:0] t);
    int gap;
    gap = tx_gaps ? gap_len() : 0;
    @(negedge clk);
    repeat (gap) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tdata  = {4'd0, t, prov, op};
    in_tvalid = 1'b1;
    #1;
    while (!in_tready) begin
      @(negedge clk);
      #1;
    end
    @(posedge clk);
    items_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic drain();
    stop_sending();
    wait (pending == 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
    @(negedge clk);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    #1;
    while (!cfg_ready) begin
      @(negedge clk);
      #1;
    end
    @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_regs(input logic [10:0] mlim, input logic [10:0] hlim,
                          input logic [7:0] en);
    write_reg(REG_MINUTE_LIMIT, mlim);
    write_reg(REG_HOUR_LIMIT, hlim);
    write_reg(REG_ENABLE, {3'd0, en});
  endtask

  // time mostly creeps forward, sometimes jumps, rarely goes back or anywhere
  task automatic advance_time();
    int r;
    r = $urandom_range(99);
    if (r < 80)      now_s = now_s + $urandom_range(20);
    else if (r < 93) now_s = now_s + $urandom_range(4000, 50);
    else if (r < 98) now_s = now_s - $urandom_range(200);
    else             now_s = $urandom;
  endtask

  task automatic random_burst(input int n);
    logic op;
    for (int i = 0; i < n; i++) begin
      advance_time();
      op = ($urandom_range(99) < 55) ? OP_RECORD : OP_CHECK;
      send_item(op, 3'($urandom_range(7)), now_s);
    end
  endtask

  initial begin
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_MINUTE_LIMIT;
    cfg_data    = '0;
    out_tready  = 1'b0;
    stall_left  = 0;
    idle_cycles = 0;
    items_sent  = 0;
    tx_gaps     = 1'b0;
    rx_stalls   = 1'b0;
    now_s       = '0;
    rst_n       = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset registers, empty log, window edges
    send_item(OP_CHECK, 3'd0, 32'd0);
    send_item(OP_RECORD, 3'd0, 32'd100);
    send_item(OP_RECORD, 3'd0, 32'd110);
    send_item(OP_CHECK, 3'd0, 32'd120);
    send_item(OP_RECORD, 3'd5, 32'd130);
    send_item(OP_CHECK, 3'd5, 32'd130);
    // entry newer than now: negative age, kept and counted in the minute
    send_item(OP_RECORD, 3'd1, 32'd5000);
    send_item(OP_CHECK, 3'd1, 32'd4000);
    // hour window edge: 3659 kept, 3660 pruned
    send_item(OP_RECORD, 3'd2, 32'd1000);
    send_item(OP_CHECK, 3'd2, 32'd4659);
    send_item(OP_CHECK, 3'd2, 32'd4660);
    // minute window edge: 59 counted, 60 not
    send_item(OP_RECORD, 3'd3, 32'd2000);
    send_item(OP_CHECK, 3'd3, 32'd2059);
    send_item(OP_CHECK, 3'd3, 32'd2060);
    // all-ones time
    send_item(OP_RECORD, 3'd4, 32'hFFFF_FFFF);
    send_item(OP_RECORD, 3'd7, 32'hFFFF_FFFF);
    send_item(OP_CHECK, 3'd0, 32'hFFFF_FFFF);
    drain();

    // zero limits: every enabled check is refused
    set_regs(11'd0, 11'd0, 8'hFF);
    send_item(OP_CHECK, 3'd4, 32'hFFFF_FFFF);
    send_item(OP_CHECK, 3'd7, 32'd0);
    send_item(OP_CHECK, 3'd6, 32'd10);
    drain();

    // limits equal to the log depth, everything enabled; a long run of records on provider 6
    set_regs(11'd1024, 11'd1024, 8'hFF);
    for (int i = 0; i < 200; i++) send_item(OP_RECORD, 3'd6, 32'd50000 + i / 20);
    send_item(OP_CHECK, 3'd6, 32'd50060);
    send_item(OP_CHECK, 3'd6, 32'd53700);
    drain();

    // random phases over a range of settings and handshake behavior
    set_regs(11'd0, 11'd1024, 8'h00);
    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
    random_burst(80);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      set_regs(11'($urandom_range(12)), 11'($urandom_range(40, 2)), 8'($urandom));
      tx_gaps   = (ph != 2);
      rx_stalls = (ph != 3);
      random_burst(30);
      // hold off until every result is back, then carry on
      drain();
      random_burst(30);
      drain();
    end
    set_regs(11'd2047, 11'd2047, 8'hFF);
    random_burst(20);
    drain();

    repeat (20) @(posedge clk);
    $display("Sent %0d items; %0d checks, %0d refused, over several limit/enable settings",
             items_sent, checks_seen, refusals_seen);
    $display("Covered window edges, backward time, pruning, gaps and output stalls");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
